// ----- design/sism_pkg.sv -----
// Package for the sorted interval set: sizes, operation codes and status codes.
// No dependencies; the interfaces, the top level and the testbench refer to it by scoped names.
package sism_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int COORD_BITS  = 32;

    localparam int OP_W  = 2;
    localparam int ST_W  = 3;
    localparam int IDX_W = 6;
    localparam int POS_W = 7;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    localparam logic [ST_W-1:0] ST_ADDED   = 3'd0;
    localparam logic [ST_W-1:0] ST_MERGED  = 3'd1;
    localparam logic [ST_W-1:0] ST_INVALID = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd3;
    localparam logic [ST_W-1:0] ST_READ    = 3'd4;
    localparam logic [ST_W-1:0] ST_CLEARED = 3'd5;
    localparam logic [ST_W-1:0] ST_RANGE   = 3'd6;

endpackage

// ----- design/sism_if.sv -----
// Valid/ready channel interfaces for the sorted interval set.
// Depends on sism_pkg for the field widths.
interface sism_in_if #(
    parameter int COORD_BITS = sism_pkg::COORD_BITS
);
    logic                       valid;
    logic                       ready;
    logic [sism_pkg::OP_W-1:0]  operation;
    logic [COORD_BITS-1:0]      seg_left;
    logic [COORD_BITS-1:0]      seg_right;
    logic [sism_pkg::IDX_W-1:0] read_index;

    modport source (output valid, operation, seg_left, seg_right, read_index, input ready);
    modport sink   (input valid, operation, seg_left, seg_right, read_index, output ready);
endinterface

interface sism_out_if #(
    parameter int COORD_BITS = sism_pkg::COORD_BITS
);
    logic                       valid;
    logic                       ready;
    logic [sism_pkg::ST_W-1:0]  status;
    logic [sism_pkg::POS_W-1:0] position;
    logic [sism_pkg::POS_W-1:0] entry_count;
    logic [COORD_BITS-1:0]      out_left;
    logic [COORD_BITS-1:0]      out_right;

    modport source (output valid, status, position, entry_count, out_left, out_right,
                    input ready);
    modport sink   (input valid, status, position, entry_count, out_left, out_right,
                    output ready);
endinterface

// ----- design/sism_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module sism_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ----- design/sorted_interval_set_merge_insert.sv -----
// Sorted interval set with union on insert: top level.
// Depends on sism_pkg, sism_in_if / sism_out_if and sism_ram.
//
// Usage. Requests arrive on i_req, a valid/ready channel; each transaction carries an
// operation (insert, clear or read), the bounds of an interval and a read index. Every
// request yields exactly one response transaction on o_rsp with a status, a position,
// the entry count after the operation and the bounds of the affected entry.
// The intervals live in a single RAM holding both bounds of an entry side by side.
// An insert scans the table from the bottom, addressing each entry visited and then
// comparing the registered read data, until it passes the new interval. It then either
// widens the first overlapping entry and closes the gap left by the merged neighbours,
// or moves the entries above the sorted position up by one, or reports a full table
// when no entry overlaps and no slot is free. Each moved entry is read, then written,
// and a merge that leaves no gap still copies every entry above onto itself.
// A new request is taken once the previous one has finished its table work, even if
// its response is still waiting in the output register; the block only stalls when a
// second response is ready while the first has not been taken.
// Reset (synchronous, active low) empties the table by clearing the entry count; the
// RAM contents are not touched and entries above the count are never read.
module sorted_interval_set_merge_insert #(
    parameter int TABLE_DEPTH = sism_pkg::TABLE_DEPTH,
    parameter int COORD_BITS  = sism_pkg::COORD_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sism_in_if.sink    i_req,
    sism_out_if.source o_rsp
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = (CW > sism_pkg::IDX_W) ? CW : sism_pkg::IDX_W;
    localparam int DW = 2 * COORD_BITS;

    typedef enum logic [9:0] {
        S_IDLE      = 10'b0000000001,
        S_SCAN_RD   = 10'b0000000010,
        S_SCAN_CHK  = 10'b0000000100,
        S_DECIDE    = 10'b0000001000,
        S_SD_RD     = 10'b0000010000,
        S_SD_WR     = 10'b0000100000,
        S_SU_RD     = 10'b0001000000,
        S_SU_WR     = 10'b0010000000,
        S_READ_WAIT = 10'b0100000000,
        S_DONE      = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    // Control registers.
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_p, n_p;
    logic [CW-1:0] r_gap, n_gap;
    logic          r_found, n_found;
    logic          r_o_valid, n_o_valid;

    // Request and result registers.
    logic [COORD_BITS-1:0]      r_sl, n_sl, r_sr, n_sr;
    logic [COORD_BITS-1:0]      r_nl, n_nl, r_nr, n_nr;
    logic [sism_pkg::ST_W-1:0]  r_res_st, n_res_st;
    logic [CW-1:0]              r_res_pos, n_res_pos;
    logic [sism_pkg::IDX_W-1:0] r_res_idx, n_res_idx;
    logic                       r_res_is_idx, n_res_is_idx;
    logic [COORD_BITS-1:0]      r_res_l, n_res_l, r_res_r, n_res_r;
    logic [sism_pkg::ST_W-1:0]  r_o_st, n_o_st;
    logic [sism_pkg::POS_W-1:0] r_o_pos, n_o_pos, r_o_cnt, n_o_cnt;
    logic [COORD_BITS-1:0]      r_o_l, n_o_l, r_o_r, n_o_r;

    // RAM port.
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [DW-1:0] wr_data, rd_data;
    logic [COORD_BITS-1:0] dl, dr;

    logic          in_acc;
    logic [CW:0]   k_gap;

    assign dl = rd_data[DW-1:COORD_BITS];
    assign dr = rd_data[COORD_BITS-1:0];

    assign i_req.ready = (r_state == S_IDLE);
    assign in_acc      = i_req.valid && i_req.ready;
    assign k_gap       = {1'b0, r_k} + {1'b0, r_gap};

    sism_ram #(
        .WIDTH (DW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_k          = r_k;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_p          = r_p;
        n_gap        = r_gap;
        n_found      = r_found;
        n_o_valid    = r_o_valid;
        n_sl         = r_sl;
        n_sr         = r_sr;
        n_nl         = r_nl;
        n_nr         = r_nr;
        n_res_st     = r_res_st;
        n_res_pos    = r_res_pos;
        n_res_idx    = r_res_idx;
        n_res_is_idx = r_res_is_idx;
        n_res_l      = r_res_l;
        n_res_r      = r_res_r;
        n_o_st       = r_o_st;
        n_o_pos      = r_o_pos;
        n_o_cnt      = r_o_cnt;
        n_o_l        = r_o_l;
        n_o_r        = r_o_r;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;
        rd_en        = 1'b0;
        rd_addr      = '0;

        if (r_o_valid && o_rsp.ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_sl         = i_req.seg_left;
                    n_sr         = i_req.seg_right;
                    n_res_idx    = i_req.read_index;
                    n_res_is_idx = 1'b0;
                    n_res_pos    = '0;
                    n_res_l      = '0;
                    n_res_r      = '0;
                    n_state      = S_DONE;
                    if (i_req.operation == sism_pkg::OP_CLEAR) begin
                        n_cnt    = '0;
                        n_res_st = sism_pkg::ST_CLEARED;
                    end else if (i_req.operation == sism_pkg::OP_READ) begin
                        n_res_is_idx = 1'b1;
                        if (XW'(i_req.read_index) < XW'(r_cnt)) begin
                            rd_en    = 1'b1;
                            rd_addr  = AW'(i_req.read_index);
                            n_res_st = sism_pkg::ST_READ;
                            n_state  = S_READ_WAIT;
                        end else begin
                            n_res_st = sism_pkg::ST_RANGE;
                        end
                    end else if (i_req.operation == sism_pkg::OP_INSERT &&
                                 i_req.seg_right >= i_req.seg_left) begin
                        n_k     = '0;
                        n_found = 1'b0;
                        n_state = S_SCAN_RD;
                    end else begin
                        n_res_st = sism_pkg::ST_INVALID;
                    end
                end
            end
            S_SCAN_RD: begin
                if (r_k == r_cnt) begin
                    n_p     = r_k;
                    n_state = S_DECIDE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_k[AW-1:0];
                    n_state = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (dr < r_sl) begin
                    n_k     = r_k + 1'b1;
                    n_state = S_SCAN_RD;
                end else if (dl <= r_sr) begin
                    if (!r_found) begin
                        n_lo = r_k;
                        n_nl = (dl < r_sl) ? dl : r_sl;
                    end
                    n_found = 1'b1;
                    n_nr    = (dr > r_sr) ? dr : r_sr;
                    n_hi    = r_k + 1'b1;
                    n_k     = r_k + 1'b1;
                    n_state = S_SCAN_RD;
                end else begin
                    n_p     = r_k;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (r_found) begin
                    wr_en   = 1'b1;
                    wr_addr = r_lo[AW-1:0];
                    wr_data = {r_nl, r_nr};
                    n_gap   = r_hi - r_lo - 1'b1;
                    n_k     = r_lo + 1'b1;
                    n_state = S_SD_RD;
                end else if (r_cnt >= CW'(TABLE_DEPTH)) begin
                    n_res_st = sism_pkg::ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    n_k     = r_cnt;
                    n_state = S_SU_RD;
                end
            end
            S_SD_RD: begin
                if (k_gap < {1'b0, r_cnt}) begin
                    rd_en   = 1'b1;
                    rd_addr = k_gap[AW-1:0];
                    n_state = S_SD_WR;
                end else begin
                    n_cnt     = r_cnt - r_gap;
                    n_res_st  = sism_pkg::ST_MERGED;
                    n_res_pos = r_lo;
                    n_res_l   = r_nl;
                    n_res_r   = r_nr;
                    n_state   = S_DONE;
                end
            end
            S_SD_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_k[AW-1:0];
                wr_data = rd_data;
                n_k     = r_k + 1'b1;
                n_state = S_SD_RD;
            end
            S_SU_RD: begin
                if (r_k > r_p) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_k - 1'b1);
                    n_state = S_SU_WR;
                end else begin
                    wr_en     = 1'b1;
                    wr_addr   = r_p[AW-1:0];
                    wr_data   = {r_sl, r_sr};
                    n_cnt     = r_cnt + 1'b1;
                    n_res_st  = sism_pkg::ST_ADDED;
                    n_res_pos = r_p;
                    n_res_l   = r_sl;
                    n_res_r   = r_sr;
                    n_state   = S_DONE;
                end
            end
            S_SU_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_k[AW-1:0];
                wr_data = rd_data;
                n_k     = r_k - 1'b1;
                n_state = S_SU_RD;
            end
            S_READ_WAIT: begin
                n_res_l = dl;
                n_res_r = dr;
                n_state = S_DONE;
            end
            S_DONE: begin
                // Hand the result to the output register once it is free.
                if (!r_o_valid || o_rsp.ready) begin
                    n_o_valid = 1'b1;
                    n_o_st    = r_res_st;
                    n_o_pos   = r_res_is_idx ? sism_pkg::POS_W'(r_res_idx)
                                             : sism_pkg::POS_W'(r_res_pos);
                    n_o_cnt   = sism_pkg::POS_W'(r_cnt);
                    n_o_l     = r_res_l;
                    n_o_r     = r_res_r;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_k       <= '0;
            r_lo      <= '0;
            r_hi      <= '0;
            r_p       <= '0;
            r_gap     <= '0;
            r_found   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_k       <= n_k;
            r_lo      <= n_lo;
            r_hi      <= n_hi;
            r_p       <= n_p;
            r_gap     <= n_gap;
            r_found   <= n_found;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sl         <= n_sl;
        r_sr         <= n_sr;
        r_nl         <= n_nl;
        r_nr         <= n_nr;
        r_res_st     <= n_res_st;
        r_res_pos    <= n_res_pos;
        r_res_idx    <= n_res_idx;
        r_res_is_idx <= n_res_is_idx;
        r_res_l      <= n_res_l;
        r_res_r      <= n_res_r;
        r_o_st       <= n_o_st;
        r_o_pos      <= n_o_pos;
        r_o_cnt      <= n_o_cnt;
        r_o_l        <= n_o_l;
        r_o_r        <= n_o_r;
    end

    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.status      = r_o_st;
    assign o_rsp.position    = r_o_pos;
    assign o_rsp.entry_count = r_o_cnt;
    assign o_rsp.out_left    = r_o_l;
    assign o_rsp.out_right   = r_o_r;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> r_state != S_IDLE)
        else $error("table written while idle");

    a_done_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_o_valid || o_rsp.ready)) |=> r_o_valid)
        else $error("finished transaction did not reach the output register");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_st == sism_pkg::ST_CLEARED) |-> r_o_cnt == '0)
        else $error("clear response reports a non-empty table");
`endif
endmodule

// ----- tb/sism_tb_if.sv -----
`timescale 1ns / 100ps
// Testbench types: the response record used by the predictor and the checker.
// Depends on sism_pkg for the field widths and the operation code width.
package sism_tb_types;
    // Operation code that the block does not define; it must be rejected.
    localparam logic [sism_pkg::OP_W-1:0] OP_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [sism_pkg::ST_W-1:0]       status;
        logic [sism_pkg::POS_W-1:0]      position;
        logic [sism_pkg::POS_W-1:0]      entry_count;
        logic [sism_pkg::COORD_BITS-1:0] out_left;
        logic [sism_pkg::COORD_BITS-1:0] out_right;
    } t_sism_rsp;
endpackage

// ----- tb/sorted_interval_set_merge_insert_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the sorted interval set with union on insert.
// Depends on sism_pkg, sism_in_if / sism_out_if, sism_tb_types and the block's RTL.
module sorted_interval_set_merge_insert_test;

    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    sism_in_if  req_ch ();
    sism_out_if rsp_ch ();

    sorted_interval_set_merge_insert dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    // Shadow copy of the interval table, advanced as each request is accepted.
    logic [31:0] shadow_left [sism_pkg::TABLE_DEPTH];
    logic [31:0] shadow_right[sism_pkg::TABLE_DEPTH];
    int          shadow_count;

    sism_tb_types::t_sism_rsp expected_rsps[$];
    int        mismatch_count = 0;
    int        idle_cycles = 0;
    bit        stall_hold = 1'b0;
    bit        sending_done = 1'b0;

    initial begin
        req_ch.valid      = 1'b0;
        req_ch.operation  = sism_pkg::OP_INSERT;
        req_ch.seg_left   = '0;
        req_ch.seg_right  = '0;
        req_ch.read_index = '0;
        rsp_ch.ready      = 1'b0;
    end

    // Works out the response of one request and updates the shadow table.
    function automatic sism_tb_types::t_sism_rsp predict_table_op(logic [1:0] op,
                                                                  logic [31:0] sl,
                                                                  logic [31:0] sr,
                                                                  logic [5:0] idx);
        sism_tb_types::t_sism_rsp r;
        int          p;
        int          hi;
        int          gap;
        logic [31:0] nl;
        logic [31:0] nr;
        r = '0;
        if (op == sism_pkg::OP_CLEAR) begin
            shadow_count = 0;
            r.status = sism_pkg::ST_CLEARED;
        end else if (op == sism_pkg::OP_READ) begin
            r.position = sism_pkg::POS_W'(idx);
            if (idx < shadow_count) begin
                r.status    = sism_pkg::ST_READ;
                r.out_left  = shadow_left[idx];
                r.out_right = shadow_right[idx];
            end else begin
                r.status = sism_pkg::ST_RANGE;
            end
        end else if (op != sism_pkg::OP_INSERT || sr < sl) begin
            r.status = sism_pkg::ST_INVALID;
        end else begin
            p = 0;
            while (p < shadow_count && shadow_right[p] < sl) p++;
            hi = p;
            while (hi < shadow_count && shadow_left[hi] <= sr) hi++;
            if (hi > p) begin
                nl = (shadow_left[p] < sl) ? shadow_left[p] : sl;
                nr = (shadow_right[hi-1] > sr) ? shadow_right[hi-1] : sr;
                shadow_left[p]  = nl;
                shadow_right[p] = nr;
                gap = hi - 1 - p;
                if (gap > 0) begin
                    for (int k = p + 1; k + gap < shadow_count; k++) begin
                        shadow_left[k]  = shadow_left[k+gap];
                        shadow_right[k] = shadow_right[k+gap];
                    end
                    shadow_count -= gap;
                end
                r.status    = sism_pkg::ST_MERGED;
                r.position  = sism_pkg::POS_W'(p);
                r.out_left  = nl;
                r.out_right = nr;
            end else if (shadow_count >= sism_pkg::TABLE_DEPTH) begin
                r.status = sism_pkg::ST_FULL;
            end else begin
                for (int k = shadow_count; k > p; k--) begin
                    shadow_left[k]  = shadow_left[k-1];
                    shadow_right[k] = shadow_right[k-1];
                end
                shadow_left[p]  = sl;
                shadow_right[p] = sr;
                shadow_count++;
                r.status    = sism_pkg::ST_ADDED;
                r.position  = sism_pkg::POS_W'(p);
                r.out_left  = sl;
                r.out_right = sr;
            end
        end
        r.entry_count = sism_pkg::POS_W'(shadow_count);
        return r;
    endfunction

    // Offers one request after a random gap and waits until it is accepted.
    // Valid stays high after acceptance when the next request follows at once.
    task automatic send_request(logic [1:0] op, logic [31:0] sl, logic [31:0] sr,
                                logic [5:0] idx);
        int gap;
        gap = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.operation  <= op;
        req_ch.seg_left   <= sl;
        req_ch.seg_right  <= sr;
        req_ch.read_index <= idx;
        do @(posedge i_clk); while (!req_ch.ready);
        expected_rsps.push_back(predict_table_op(op, sl, sr, idx));
    endtask

    task automatic send_insert(logic [31:0] sl, logic [31:0] sr);
        send_request(sism_pkg::OP_INSERT, sl, sr, 6'($urandom));
    endtask

    task automatic test_directed_cases();
        send_request(sism_pkg::OP_READ, $urandom, $urandom, 6'd0);
        send_insert(32'd100, 32'd200);
        send_insert(32'd300, 32'd400);
        send_insert(32'd201, 32'd299);              // touches both ends only
        send_insert(32'd150, 32'd350);              // spans several entries
        send_insert(32'd0, 32'd0);
        send_insert(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_insert(32'd10, 32'd5);                 // right below left
        send_insert(32'hFFFF_FFFF, 32'd0);
        send_request(sism_tb_types::OP_UNKNOWN, $urandom, $urandom, 6'($urandom));
        send_request(sism_pkg::OP_READ, '0, '0, 6'd1);
        send_request(sism_pkg::OP_READ, '0, '0, 6'd63);
        send_insert(32'd0, 32'hFFFF_FFFF);          // swallows the whole table
        send_request(sism_pkg::OP_READ, '0, '0, 6'd0);
        send_request(sism_pkg::OP_CLEAR, $urandom, $urandom, 6'($urandom));
        send_request(sism_pkg::OP_READ, '0, '0, 6'd0);
    endtask

    // Fills the table to its depth, then checks dropping and merging while full.
    task automatic test_full_table();
        send_request(sism_pkg::OP_CLEAR, '0, '0, '0);
        for (int i = 0; i < sism_pkg::TABLE_DEPTH; i++)
            send_insert(i * 10 + 1000, i * 10 + 1003);
        send_insert(32'd5, 32'd6);
        send_insert(32'hFFFF_0000, 32'hFFFF_FFFF);
        send_insert(32'd1002, 32'd1011);
        send_request(sism_pkg::OP_READ, '0, '0, 6'd63);
        send_insert(32'd5, 32'd6);
        send_insert(32'd7, 32'd8);
    endtask

    // Random traffic in small coordinate windows so overlaps are common; the
    // receiver holds off at one point while requests keep coming.
    task automatic test_random_traffic(int n_items);
        logic [31:0] base;
        logic [31:0] sl;
        logic [31:0] sr;
        int          pick;
        for (int i = 0; i < n_items; i++) begin
            if (i == n_items / 3) stall_hold = 1'b1;
            pick = $urandom_range(0, 99);
            base = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
            if (pick < 70) begin
                sl = base + $urandom_range(0, 2000);
                sr = ($urandom_range(0, 9) == 0) ? sl - $urandom_range(1, 50)
                                                  : sl + $urandom_range(0, 60);
                if (sr < sl && base != 0 && $urandom_range(0, 1)) sr = $urandom;
                send_insert(sl, sr);
            end else if (pick < 95) begin
                send_request(sism_pkg::OP_READ, $urandom, $urandom, 6'($urandom));
            end else if (pick < 98) begin
                send_request(sism_pkg::OP_CLEAR, $urandom, $urandom, 6'($urandom));
            end else begin
                send_request(sism_tb_types::OP_UNKNOWN, $urandom, $urandom, 6'($urandom));
            end
        end
    endtask

    // Receiver: random readiness, plus one long hold-off requested by the stimulus.
    initial begin
        int wait_cycles;
        @(posedge i_rst_n);
        forever begin
            if (stall_hold) begin
                rsp_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                stall_hold = 1'b0;
            end
            wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
            if (wait_cycles > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
        end
    end

    // Checks each accepted response against the oldest prediction.
    always @(posedge i_clk) begin
        sism_tb_types::t_sism_rsp got;
        sism_tb_types::t_sism_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.status, rsp_ch.position, rsp_ch.entry_count,
                   rsp_ch.out_left, rsp_ch.out_right};
            if (expected_rsps.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected response transaction: %p", got);
            end else begin
                want = expected_rsps.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %p, actual %p", want, got);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (sending_done && expected_rsps.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        shadow_count = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_full_table();
        test_random_traffic(370);
        req_ch.valid <= 1'b0;
        sending_done = 1'b1;
        wait (expected_rsps.size() == 0);
        repeat (300) @(posedge i_clk);
        if (mismatch_count == 0 && expected_rsps.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
